// ===== rtl/tapu_pkg.sv =====
// ----------------------------------------------------------------------------
// tapu_pkg
// Shared types and constants of the tanh/atanh rational approximation unit.
// ----------------------------------------------------------------------------
package tapu_pkg;

   localparam int FRAC_BITS = 12;
   localparam int X_W       = 18;
   localparam int Y_W       = 15;
   localparam int Y_MAX     = 16383;
   localparam int Y_MIN     = -16384;
   localparam int SCALE     = 1 << FRAC_BITS;

   // largest tanh argument that still goes through the rational approximation
   localparam int TANH_LIM  = (497 * SCALE) / 100;

   // magnitude < 5 * scale, x^2 < 25 * scale, x^4 < 625 * scale (all scaled)
   localparam int MAG_W  = FRAC_BITS + 3;
   localparam int T_W    = FRAC_BITS + 5;
   localparam int U_W    = FRAC_BITS + 10;
   localparam int ND_W   = FRAC_BITS + 17;
   localparam int NUM_W  = FRAC_BITS + 13;
   localparam int DEN_W  = FRAC_BITS + 15;
   localparam int DV_W   = MAG_W + NUM_W;

   // quotient bits resolved by the divider, one per stage, plus an overflow stage
   localparam int QB      = 16;
   localparam int DIV_STG = QB + 1;

   localparam int ONE_POS = (SCALE > Y_MAX) ? Y_MAX : SCALE;
   localparam int ONE_NEG = (-SCALE < Y_MIN) ? Y_MIN : -SCALE;

   typedef enum logic {
      OP_TANH  = 1'b0,
      OP_ATANH = 1'b1
   } op_type;

   typedef struct packed {
      logic neg;
      logic clamp;
      logic bad;
   } tag_type;

   typedef struct packed {
      op_type             op;
      logic               neg;
      logic               clamp;
      logic               bad;
      logic [MAG_W-1:0]   mag;
      logic [T_W-1:0]     t;
      logic [U_W-1:0]     u;
      logic [NUM_W-1:0]   num;
      logic [DEN_W-1:0]   den;
   } front_type;

   typedef struct packed {
      logic [DV_W-1:0]  dividend;
      logic [DEN_W-1:0] den;
      tag_type          tag;
   } div_in_type;

   typedef struct packed {
      logic [DV_W-1:0]  rem;
      logic [DEN_W-1:0] den;
      logic [QB-1:0]    q;
      logic             ovf;
      tag_type          tag;
   } div_stage_type;

   typedef struct packed {
      logic [QB-1:0] q;
      logic          ovf;
      tag_type       tag;
   } div_out_type;

endpackage

// ===== rtl/tapu_req_if.sv =====
// ----------------------------------------------------------------------------
// tapu_req_if
// Request channel: operation select and fixed-point argument.
// ----------------------------------------------------------------------------
interface tapu_req_if;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [17:0]       x;

   modport source (output valid, output op, output x, input ready);
   modport sink   (input valid, input op, input x, output ready);
endinterface

// ===== rtl/tapu_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tapu_rsp_if
// Response channel: saturated fixed-point result.
// ----------------------------------------------------------------------------
interface tapu_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [14:0]       y;

   modport source (output valid, output y, input ready);
   modport sink   (input valid, input y, output ready);
endinterface

// ===== rtl/tapu_div.sv =====
// ----------------------------------------------------------------------------
// tapu_div
// Pipelined restoring divider: an overflow check, then one quotient bit per
// stage. Each stage holds its item until the next one can take it.
// ----------------------------------------------------------------------------
module tapu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  tapu_pkg::div_in_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output tapu_pkg::div_out_type out_data
);
   import tapu_pkg::*;

   div_stage_type      st_ff [DIV_STG];
   div_stage_type      st_in [DIV_STG];
   logic [DIV_STG-1:0] v_ff;
   logic [DIV_STG:0]   rdy;

   always_comb begin
      rdy[DIV_STG] = out_ready;
      for (int k = DIV_STG - 1; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   // quotient must fit in QB bits, otherwise flag it and skip the steps
   always_comb begin
      st_in[0].rem = in_data.dividend;
      st_in[0].den = in_data.den;
      st_in[0].q   = '0;
      st_in[0].ovf = (in_data.dividend >> QB) >= DV_W'(in_data.den);
      st_in[0].tag = in_data.tag;
   end

   for (genvar k = 1; k < DIV_STG; k++) begin : g_step
      localparam int B = QB - k;
      always_comb begin
         st_in[k] = st_ff[k-1];
         if (!st_ff[k-1].ovf && ((st_ff[k-1].rem >> B) >= DV_W'(st_ff[k-1].den))) begin
            st_in[k].rem  = st_ff[k-1].rem - (DV_W'(st_ff[k-1].den) << B);
            st_in[k].q[B] = 1'b1;
         end
      end
   end

   for (genvar k = 0; k < DIV_STG; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready      = rdy[0];
   assign out_valid     = v_ff[DIV_STG-1];
   assign out_data.q    = st_ff[DIV_STG-1].q;
   assign out_data.ovf  = st_ff[DIV_STG-1].ovf;
   assign out_data.tag  = st_ff[DIV_STG-1].tag;

endmodule

// ===== rtl/tanh_atanh_pade_unit.sv =====
// ----------------------------------------------------------------------------
// tanh_atanh_pade_unit
// Rational (Pade) approximation of tanh and atanh in fixed point.
// ----------------------------------------------------------------------------
// One request enters per cycle unless a stalled response has filled the pipe,
// and passes through five front stages (clamp and magnitude, x^2, x^4,
// numerator and denominator, dividend product), a 17-stage divider that
// resolves one quotient bit per stage after an overflow check, and the output
// register with sign and saturation. Throughput is one result per cycle while
// responses are taken, and a stalled response only holds the stages that are full.
module tanh_atanh_pade_unit (
   input  logic      clock,
   input  logic      reset,
   tapu_req_if.sink  req_ch,
   tapu_rsp_if.source rsp_ch
);
   import tapu_pkg::*;

   front_type a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic      a_v_ff, b_v_ff, c_v_ff, d_v_ff, e_v_ff;
   logic      rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

   div_in_type  e_ff, e_in;
   div_out_type dv_out;
   logic        dv_in_ready, dv_out_valid;

   logic                  o_v_ff;
   logic signed [Y_W-1:0] y_ff, y_in;
   tag_type               o_tag_ff;
   logic                  o_ovf_ff;

   assign rdy_o = !o_v_ff || rsp_ch.ready;
   assign rdy_e = !e_v_ff || dv_in_ready;
   assign rdy_d = !d_v_ff || rdy_e;
   assign rdy_c = !c_v_ff || rdy_d;
   assign rdy_b = !b_v_ff || rdy_c;
   assign rdy_a = !a_v_ff || rdy_b;
   assign req_ch.ready = rdy_a;

   // stage a: range handling and magnitude
   always_comb begin
      int xi;
      int xc;
      xi = int'(req_ch.x);
      xc = xi;
      a_in     = '0;
      a_in.op  = op_type'(req_ch.op);
      a_in.neg = req_ch.x[X_W-1];
      unique case (op_type'(req_ch.op))
         OP_TANH: begin
            a_in.clamp = (xi > TANH_LIM) || (xi < -TANH_LIM);
         end
         OP_ATANH: begin
            if (xi > SCALE) xc = SCALE;
            if (xi < -SCALE) xc = -SCALE;
         end
         default: begin
            a_in.clamp = 1'b0;
         end
      endcase
      if (!a_in.clamp) begin
         a_in.mag = MAG_W'((xc < 0) ? -xc : xc);
      end
   end

   // stage b: x^2
   always_comb begin
      logic [2*MAG_W-1:0] sq;
      sq   = {{MAG_W{1'b0}}, a_ff.mag} * {{MAG_W{1'b0}}, a_ff.mag};
      b_in = a_ff;
      b_in.t = sq[FRAC_BITS +: T_W];
   end

   // stage c: x^4
   always_comb begin
      logic [2*T_W-1:0] sq;
      sq   = {{T_W{1'b0}}, b_ff.t} * {{T_W{1'b0}}, b_ff.t};
      c_in = b_ff;
      c_in.u = sq[FRAC_BITS +: U_W];
   end

   // stage d: numerator and denominator, both scaled
   always_comb begin
      logic signed [ND_W-1:0] ts, us, num, den;
      ts = signed'(ND_W'(c_ff.t));
      us = signed'(ND_W'(c_ff.u));
      d_in = c_ff;
      if (c_ff.op == OP_TANH) begin
         num = ND_W'(945 * SCALE) + ND_W'(105) * ts + us;
         den = ND_W'(945 * SCALE) + ND_W'(420) * ts + ND_W'(15) * us;
      end else begin
         num = ND_W'(945 * SCALE) - ND_W'(735) * ts + ND_W'(64) * us;
         den = ND_W'(945 * SCALE) - ND_W'(1050) * ts + ND_W'(225) * us;
      end
      d_in.bad = (den <= 0);
      d_in.num = NUM_W'(num);
      d_in.den = DEN_W'(den);
   end

   // stage e: dividend = |x| * numerator
   always_comb begin
      e_in.dividend = DV_W'(d_ff.mag) * DV_W'(d_ff.num);
      e_in.den      = d_ff.den;
      e_in.tag.neg   = d_ff.neg;
      e_in.tag.clamp = d_ff.clamp;
      e_in.tag.bad   = d_ff.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (rdy_a) a_v_ff <= req_ch.valid;
         if (rdy_b) b_v_ff <= a_v_ff;
         if (rdy_c) c_v_ff <= b_v_ff;
         if (rdy_d) d_v_ff <= c_v_ff;
         if (rdy_e) e_v_ff <= d_v_ff;
         if (rdy_o) o_v_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a) a_ff <= a_in;
      if (rdy_b) b_ff <= b_in;
      if (rdy_c) c_ff <= c_in;
      if (rdy_d) d_ff <= d_in;
      if (rdy_e) e_ff <= e_in;
      if (rdy_o) begin
         y_ff     <= y_in;
         o_tag_ff <= dv_out.tag;
         o_ovf_ff <= dv_out.ovf;
      end
   end

   tapu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_v_ff),
      .in_ready  (dv_in_ready),
      .in_data   (e_ff),
      .out_valid (dv_out_valid),
      .out_ready (rdy_o),
      .out_data  (dv_out)
   );

   // sign and saturation
   always_comb begin
      logic [QB-1:0] qn;
      qn = -dv_out.q;
      if (dv_out.tag.clamp) begin
         y_in = dv_out.tag.neg ? Y_W'(ONE_NEG) : Y_W'(ONE_POS);
      end else if (dv_out.tag.bad || dv_out.ovf) begin
         y_in = dv_out.tag.neg ? Y_W'(Y_MIN) : Y_W'(Y_MAX);
      end else if (dv_out.tag.neg) begin
         y_in = (dv_out.q > QB'(-Y_MIN)) ? Y_W'(Y_MIN) : signed'(qn[Y_W-1:0]);
      end else begin
         y_in = (dv_out.q > QB'(Y_MAX)) ? Y_W'(Y_MAX) : signed'(dv_out.q[Y_W-1:0]);
      end
   end

   assign rsp_ch.valid = o_v_ff;
   assign rsp_ch.y     = y_ff;

   a_reset_empty : assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_ch.valid)
      else $error("response valid right after reset");

   a_front_hold : assert property (@(posedge clock) disable iff (reset)
      a_v_ff && !rdy_b |=> a_v_ff)
      else $error("stalled front stage lost its request");

   a_sign : assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !o_tag_ff.neg |-> !y_ff[Y_W-1])
      else $error("non-negative argument gave a negative result");

   a_no_ovf : assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !o_tag_ff.clamp && !o_tag_ff.bad |-> !o_ovf_ff)
      else $error("quotient overflow inside the approximation range");

   a_den_ok : assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !o_tag_ff.clamp |-> !o_tag_ff.bad)
      else $error("non-positive denominator");

endmodule
